// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL. Define NO_ASSERTIONS to strip
// them from a build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/qmr_pkg.sv -----
// ----------------------------------------------------------------------------
// qmr_pkg
// Operation codes, datapath widths and rounding constants of the quaternion
// product / rotation core.
// ----------------------------------------------------------------------------
package qmr_pkg;

   // operation codes carried in the request tuser
   typedef enum logic [1:0] {
      OP_MUL           = 2'd0,  // a*b
      OP_CONJ_SANDWICH = 2'd1,  // conj(a)*b*a
      OP_ROTATE        = 2'd2   // a*(0,b_xyz)*conj(a)
   } op_type;

   // component width and fraction bits of Q2.14
   localparam int unsigned Q_W   = 16;
   localparam int unsigned QFRAC = 14;

   // operand width: one more bit so that -(-32768) stays exact
   localparam int unsigned P_W  = Q_W + 1;
   // first product, first sum
   localparam int unsigned M1_W = 2 * P_W;
   localparam int unsigned T_W  = M1_W + 2;
   // second product, second sum
   localparam int unsigned M2_W = T_W + P_W;
   localparam int unsigned R_W  = M2_W + 2;

   // every second sum has scale 2^42 (op 0 is multiplied by 1.0 once more)
   localparam int unsigned SHIFT = 2 * QFRAC;
   localparam int unsigned Y_W   = R_W + 1 - SHIFT;

   // 1.0 in Q2.14
   localparam logic signed [P_W-1:0] ONE_Q = P_W'(1 << QFRAC);

   // saturation limits at the rounded width
   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((1 << (Q_W - 1)) - 1);
   localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(1 << (Q_W - 1));

   // output limits at component width
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (Q_W - 1)) - 1);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(1 << (Q_W - 1));

   typedef logic signed [P_W-1:0]  opnd_type;
   typedef logic signed [M1_W-1:0] prod1_type;
   typedef logic signed [T_W-1:0]  sum1_type;
   typedef logic signed [M2_W-1:0] prod2_type;
   typedef logic signed [R_W-1:0]  sum2_type;

endpackage

// ----- rtl/core/quaternion_multiply_rotate_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_core
// Hamilton product, conjugate sandwich and vector rotation of Q2.14
// quaternions, six register stages deep.
// ----------------------------------------------------------------------------
// Usage:
//   Request beat: req_tdata carries a (w,x,y,z) then b (w,x,y,z), 16 bits
//   each, req_tuser the operation (0 a*b, 1 conj(a)*b*a, 2 a*b*conj(a) with
//   b_w taken as zero). Response beat: rsp_tdata carries r (w,x,y,z), rsp_tuser
//   the saturation flag. Operation code 3 answers with all zeros.
//   An accepted beat moves through stages 1 to 6 to rsp_tvalid. One beat is
//   taken every cycle while req_tready is high; each of the six stages is
//   one register level (operand select, 16 multipliers, 4-term sums, 16
//   multipliers, 4-term sums, round and clip); the two multiplier banks set the clock.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up while the output is stalled.
//   A stall on rsp_tready holds the output beat; req_tready falls only once
//   every stage holds a beat. Synchronous reset empties all stages; the payload
//   registers have no reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_multiply_rotate_core (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
   input  logic [1:0]   req_tuser,   // req_type
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // r_w, r_x, r_y, r_z
   output logic [0:0]   rsp_tuser    // saturated
);

   localparam int unsigned NQ = 4;

   // stage valid bits and ready chain
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   // stage payloads
   qmr_pkg::op_type    s1_op_ff, s2_op_ff, s3_op_ff, s4_op_ff, s5_op_ff, s6_op_ff;
   qmr_pkg::opnd_type  s1_p_ff [NQ];
   qmr_pkg::opnd_type  s1_q_ff [NQ];
   qmr_pkg::opnd_type  s1_s_ff [NQ];
   qmr_pkg::opnd_type  s2_s_ff [NQ];
   qmr_pkg::opnd_type  s3_s_ff [NQ];
   qmr_pkg::prod1_type s2_m_ff [NQ*NQ];
   qmr_pkg::sum1_type  s3_t_ff [NQ];
   qmr_pkg::prod2_type s4_m_ff [NQ*NQ];
   qmr_pkg::sum2_type  s5_r_ff [NQ];
   logic [63:0]        s6_data_ff;
   logic               s6_sat_ff;

   // next values
   qmr_pkg::op_type    s1_op_in;
   qmr_pkg::opnd_type  s1_p_in [NQ];
   qmr_pkg::opnd_type  s1_q_in [NQ];
   qmr_pkg::opnd_type  s1_s_in [NQ];
   qmr_pkg::prod1_type s2_m_in [NQ*NQ];
   qmr_pkg::sum1_type  s3_t_in [NQ];
   qmr_pkg::prod2_type s4_m_in [NQ*NQ];
   qmr_pkg::sum2_type  s5_r_in [NQ];
   logic [63:0]        s6_data_in;
   logic               s6_sat_in;

   qmr_pkg::opnd_type  a_q [NQ];
   qmr_pkg::opnd_type  b_q [NQ];

   // a stage loads when empty or when its beat moves on
   assign rdy6 = !s6_v_ff || rsp_tready;
   assign rdy5 = !s5_v_ff || rdy6;
   assign rdy4 = !s4_v_ff || rdy5;
   assign rdy3 = !s3_v_ff || rdy4;
   assign rdy2 = !s2_v_ff || rdy3;
   assign rdy1 = !s1_v_ff || rdy2;

   assign req_tready = rdy1;
   assign rsp_tvalid = s6_v_ff;
   assign rsp_tdata  = s6_data_ff;
   assign rsp_tuser  = s6_sat_ff;

   // unpack and widen request components
   always_comb begin
      for (int k = 0; k < NQ; k++) begin
         a_q[k] = qmr_pkg::P_W'($signed(req_tdata[16*k +: 16]));
         b_q[k] = qmr_pkg::P_W'($signed(req_tdata[64 + 16*k +: 16]));
      end
   end

   // stage 1 operands: first product p*q, second factor s
   always_comb begin
      s1_op_in = qmr_pkg::op_type'(req_tuser);
      for (int k = 0; k < NQ; k++) begin
         s1_p_in[k] = '0;
         s1_q_in[k] = '0;
         s1_s_in[k] = '0;
      end
      case (s1_op_in)
         qmr_pkg::OP_MUL: begin
            for (int k = 0; k < NQ; k++) begin
               s1_p_in[k] = a_q[k];
               s1_q_in[k] = b_q[k];
            end
            // multiply by 1.0 so that all operations share the final scale
            s1_s_in[0] = qmr_pkg::ONE_Q;
         end
         qmr_pkg::OP_CONJ_SANDWICH: begin
            s1_p_in[0] = a_q[0];
            for (int k = 1; k < NQ; k++) s1_p_in[k] = -a_q[k];
            for (int k = 0; k < NQ; k++) begin
               s1_q_in[k] = b_q[k];
               s1_s_in[k] = a_q[k];
            end
         end
         qmr_pkg::OP_ROTATE: begin
            for (int k = 0; k < NQ; k++) s1_p_in[k] = a_q[k];
            for (int k = 1; k < NQ; k++) s1_q_in[k] = b_q[k];
            s1_s_in[0] = a_q[0];
            for (int k = 1; k < NQ; k++) s1_s_in[k] = -a_q[k];
         end
         default: begin
         end
      endcase
   end

   // stage 2: all sixteen cross products p_i*q_j
   always_comb begin
      for (int i = 0; i < NQ; i++) begin
         for (int j = 0; j < NQ; j++) begin
            s2_m_in[NQ*i + j] = s1_p_ff[i] * s1_q_ff[j];
         end
      end
   end

   // stage 3: Hamilton combination of the first products
   always_comb begin
      s3_t_in[0] = qmr_pkg::T_W'(s2_m_ff[0])  - qmr_pkg::T_W'(s2_m_ff[5])
                 - qmr_pkg::T_W'(s2_m_ff[10]) - qmr_pkg::T_W'(s2_m_ff[15]);
      s3_t_in[1] = qmr_pkg::T_W'(s2_m_ff[1])  + qmr_pkg::T_W'(s2_m_ff[4])
                 + qmr_pkg::T_W'(s2_m_ff[11]) - qmr_pkg::T_W'(s2_m_ff[14]);
      s3_t_in[2] = qmr_pkg::T_W'(s2_m_ff[2])  - qmr_pkg::T_W'(s2_m_ff[7])
                 + qmr_pkg::T_W'(s2_m_ff[8])  + qmr_pkg::T_W'(s2_m_ff[13]);
      s3_t_in[3] = qmr_pkg::T_W'(s2_m_ff[3])  + qmr_pkg::T_W'(s2_m_ff[6])
                 - qmr_pkg::T_W'(s2_m_ff[9])  + qmr_pkg::T_W'(s2_m_ff[12]);
   end

   // stage 4: cross products t_i*s_j
   always_comb begin
      for (int i = 0; i < NQ; i++) begin
         for (int j = 0; j < NQ; j++) begin
            s4_m_in[NQ*i + j] = s3_t_ff[i] * s3_s_ff[j];
         end
      end
   end

   // stage 5: Hamilton combination of the second products
   always_comb begin
      s5_r_in[0] = qmr_pkg::R_W'(s4_m_ff[0])  - qmr_pkg::R_W'(s4_m_ff[5])
                 - qmr_pkg::R_W'(s4_m_ff[10]) - qmr_pkg::R_W'(s4_m_ff[15]);
      s5_r_in[1] = qmr_pkg::R_W'(s4_m_ff[1])  + qmr_pkg::R_W'(s4_m_ff[4])
                 + qmr_pkg::R_W'(s4_m_ff[11]) - qmr_pkg::R_W'(s4_m_ff[14]);
      s5_r_in[2] = qmr_pkg::R_W'(s4_m_ff[2])  - qmr_pkg::R_W'(s4_m_ff[7])
                 + qmr_pkg::R_W'(s4_m_ff[8])  + qmr_pkg::R_W'(s4_m_ff[13]);
      s5_r_in[3] = qmr_pkg::R_W'(s4_m_ff[3])  + qmr_pkg::R_W'(s4_m_ff[6])
                 - qmr_pkg::R_W'(s4_m_ff[9])  + qmr_pkg::R_W'(s4_m_ff[12]);
   end

   // stage 6: round half up, floor shift, clip to Q2.14
   always_comb begin
      logic signed [qmr_pkg::R_W:0]   rnd;
      logic signed [qmr_pkg::Y_W-1:0] y;
      logic signed [qmr_pkg::Q_W-1:0] c;
      s6_data_in = '0;
      s6_sat_in  = 1'b0;
      for (int k = 0; k < NQ; k++) begin
         rnd = (qmr_pkg::R_W + 1)'(s5_r_ff[k])
             + (qmr_pkg::R_W + 1)'(1 << (qmr_pkg::SHIFT - 1));
         y   = $signed(rnd[qmr_pkg::R_W:qmr_pkg::SHIFT]);
         if (y > qmr_pkg::Y_MAX) begin
            c         = qmr_pkg::Q_MAX;
            s6_sat_in = 1'b1;
         end else if (y < qmr_pkg::Y_MIN) begin
            c         = qmr_pkg::Q_MIN;
            s6_sat_in = 1'b1;
         end else begin
            c = y[qmr_pkg::Q_W-1:0];
         end
         s6_data_in[16*k +: 16] = c;
      end
      // unused code answers with zeros
      case (s5_op_ff)
         qmr_pkg::OP_MUL, qmr_pkg::OP_CONJ_SANDWICH, qmr_pkg::OP_ROTATE: begin
         end
         default: begin
            s6_data_in = '0;
            s6_sat_in  = 1'b0;
         end
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (rdy1) s1_v_ff <= req_tvalid;
         if (rdy2) s2_v_ff <= s1_v_ff;
         if (rdy3) s3_v_ff <= s2_v_ff;
         if (rdy4) s4_v_ff <= s3_v_ff;
         if (rdy5) s5_v_ff <= s4_v_ff;
         if (rdy6) s6_v_ff <= s5_v_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_op_ff <= s1_op_in;
         s1_p_ff  <= s1_p_in;
         s1_q_ff  <= s1_q_in;
         s1_s_ff  <= s1_s_in;
      end
      if (rdy2) begin
         s2_op_ff <= s1_op_ff;
         s2_m_ff  <= s2_m_in;
         s2_s_ff  <= s1_s_ff;
      end
      if (rdy3) begin
         s3_op_ff <= s2_op_ff;
         s3_t_ff  <= s3_t_in;
         s3_s_ff  <= s2_s_ff;
      end
      if (rdy4) begin
         s4_op_ff <= s3_op_ff;
         s4_m_ff  <= s4_m_in;
      end
      if (rdy5) begin
         s5_op_ff <= s4_op_ff;
         s5_r_ff  <= s5_r_in;
      end
      if (rdy6) begin
         s6_op_ff   <= s5_op_ff;
         s6_data_ff <= s6_data_in;
         s6_sat_ff  <= s6_sat_in;
      end
   end

   // a ready sink never backs up into the request side
   `ASSERT_IMPLIES(a_no_false_stall, clock, reset, rsp_tready, req_tready)

   // rotation of a pure vector has no scalar part
   `ASSERT_IMPLIES(a_rotate_w_zero, clock, reset,
                   rsp_tvalid && (s6_op_ff == qmr_pkg::OP_ROTATE),
                   rsp_tdata[15:0] == 16'h0000)

   // unused code gives an all-zero beat
   `ASSERT_IMPLIES(a_unused_zero, clock, reset,
                   rsp_tvalid && (s6_op_ff != qmr_pkg::OP_MUL)
                   && (s6_op_ff != qmr_pkg::OP_CONJ_SANDWICH)
                   && (s6_op_ff != qmr_pkg::OP_ROTATE),
                   (rsp_tdata == 64'h0) && !rsp_tuser[0])

   // the flag implies at least one component sits at a limit
   `ASSERT_ALWAYS(a_sat_at_limit, clock, reset,
                  !(rsp_tvalid && rsp_tuser[0])
                  || (rsp_tdata[15:0] == 16'h7fff) || (rsp_tdata[15:0] == 16'h8000)
                  || (rsp_tdata[31:16] == 16'h7fff) || (rsp_tdata[31:16] == 16'h8000)
                  || (rsp_tdata[47:32] == 16'h7fff) || (rsp_tdata[47:32] == 16'h8000)
                  || (rsp_tdata[63:48] == 16'h7fff) || (rsp_tdata[63:48] == 16'h8000))

endmodule
